[sv/assert_macros.svh]
// assertion macros shared by the tokenizer rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define STT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/stt_pkg.sv]
// types, codes and character classes for the scene text tokenizer
// no dependencies; imported by scene_text_tokenizer_core
package stt_pkg;

    localparam int LINE_BITS = 20;

    // event codes
    localparam logic [2:0] EV_CHAR   = 3'd0;
    localparam logic [2:0] EV_END    = 3'd1;
    localparam logic [2:0] EV_ABEGIN = 3'd2;
    localparam logic [2:0] EV_AEND   = 3'd3;
    localparam logic [2:0] EV_EOF    = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    // token classes
    localparam logic [1:0] CL_NONE    = 2'd0;
    localparam logic [1:0] CL_NUMBER  = 2'd1;
    localparam logic [1:0] CL_STRING  = 2'd2;
    localparam logic [1:0] CL_KEYWORD = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_UNTERM = 2'd2;

    // character constants
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_E      = 8'h65;

    typedef enum logic [7:0] {
        M_IDLE     = 8'b0000_0001,
        M_COMMENT  = 8'b0000_0010,
        M_NUMBER   = 8'b0000_0100,
        M_STRING   = 8'b0000_1000,
        M_ESCAPE   = 8'b0001_0000,
        M_KEYWORD  = 8'b0010_0000,
        M_ERR_CHAR = 8'b0100_0000,
        M_ERR_STR  = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           event_res;
        logic [1:0]           token_class;
        logic [7:0]           out_char;
        logic [1:0]           error_code;
        logic [LINE_BITS-1:0] line_number;
        logic                 last;
    } out_item_t;

    // outcome of lexing one character from the idle mode
    typedef struct packed {
        logic      emit;
        out_item_t res;
        mode_t     mode;
        logic      inc;
    } idle_step_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_num_start(input logic [7:0] c);
        return is_digit(c) || (c == CH_DOT) || (c == CH_MINUS) || (c == CH_PLUS);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    // classify a character seen between tokens
    function automatic idle_step_t lex_idle(input logic [7:0] c);
        idle_step_t s;
        s = '0;
        s.mode = M_IDLE;
        if ((c == CH_SPACE) || (c == CH_TAB))
        begin
            s.emit = 1'b0;
        end
        else if (c == CH_NL)
        begin
            s.inc = 1'b1;
        end
        else if (c == CH_HASH)
        begin
            s.inc = 1'b1;
            s.mode = M_COMMENT;
        end
        else if (is_num_start(c))
        begin
            s.emit = 1'b1;
            s.res.event_res = EV_CHAR;
            s.res.token_class = CL_NUMBER;
            s.res.out_char = c;
            s.mode = M_NUMBER;
        end
        else if (c == CH_QUOTE)
        begin
            s.mode = M_STRING;
        end
        else if (c == CH_LBRACK)
        begin
            s.emit = 1'b1;
            s.res.event_res = EV_ABEGIN;
        end
        else if (c == CH_RBRACK)
        begin
            s.emit = 1'b1;
            s.res.event_res = EV_AEND;
        end
        else if (is_alpha(c))
        begin
            s.emit = 1'b1;
            s.res.event_res = EV_CHAR;
            s.res.token_class = CL_KEYWORD;
            s.res.out_char = c;
            s.mode = M_KEYWORD;
        end
        else
        begin
            s.emit = 1'b1;
            s.res.event_res = EV_ERROR;
            s.res.error_code = ERR_CHAR;
            s.mode = M_ERR_CHAR;
        end
        return s;
    endfunction

endpackage

[sv/scene_text_tokenizer_core.sv]
// the first result of an item is offered in the cycle after its transfer
// one item per cycle while out_ready is high; an item giving two results holds the input
// until its first result is taken, as the two-entry result queue drains one result per cycle
// reset: rst_n clears mode to idle, line count to one and empties the result queue
// depends on stt_pkg and assert_macros.svh
`include "assert_macros.svh"

module scene_text_tokenizer_core
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    mode_t                mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_count_reg, line_count_next;
    logic [1:0]           cnt_reg, cnt_next;
    out_item_t            q0_reg, q0_next;
    out_item_t            q1_reg, q1_next;

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] n_res;
    logic       inc;
    out_item_t  r0, r1;
    idle_step_t st;
    logic [7:0] c;

    assign c         = in_data.char_code;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = q0_reg;
    assign out_xfer  = out_valid && out_ready;
    // new item only when the queue is empty after this cycle's transfer
    assign in_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign in_xfer   = in_valid && in_ready;

    // lexer step for the presented item
    always_comb
    begin
        r0        = '0;
        r1        = '0;
        n_res     = 2'd0;
        inc       = 1'b0;
        mode_next = mode_reg;
        st        = lex_idle(c);
        if (mode_reg == M_ERR_CHAR)
        begin
            r0.event_res  = EV_ERROR;
            r0.error_code = ERR_CHAR;
            n_res         = 2'd1;
        end
        else if (mode_reg == M_ERR_STR)
        begin
            r0.event_res  = EV_ERROR;
            r0.error_code = ERR_UNTERM;
            n_res         = 2'd1;
        end
        else if (in_data.end_of_input)
        begin
            if ((mode_reg == M_STRING) || (mode_reg == M_ESCAPE))
            begin
                r0.event_res  = EV_ERROR;
                r0.error_code = ERR_UNTERM;
                n_res         = 2'd1;
                mode_next     = M_ERR_STR;
            end
            else if ((mode_reg == M_NUMBER) || (mode_reg == M_KEYWORD))
            begin
                r0.event_res   = EV_END;
                r0.token_class = (mode_reg == M_NUMBER) ? CL_NUMBER : CL_KEYWORD;
                r1.event_res   = EV_EOF;
                n_res          = 2'd2;
                mode_next      = M_IDLE;
            end
            else
            begin
                r0.event_res = EV_EOF;
                n_res        = 2'd1;
                mode_next    = M_IDLE;
            end
        end
        else
        begin
            unique case (mode_reg)
                M_COMMENT:
                begin
                    if (c == CH_NL)
                    begin
                        mode_next = M_IDLE;
                    end
                end
                M_NUMBER:
                begin
                    if (is_num_start(c) || (c == CH_E))
                    begin
                        r0.event_res   = EV_CHAR;
                        r0.token_class = CL_NUMBER;
                        r0.out_char    = c;
                        n_res          = 2'd1;
                    end
                    else
                    begin
                        r0.event_res   = EV_END;
                        r0.token_class = CL_NUMBER;
                        r1             = st.res;
                        n_res          = st.emit ? 2'd2 : 2'd1;
                        mode_next      = st.mode;
                        inc            = st.inc;
                    end
                end
                M_KEYWORD:
                begin
                    if (!is_ws(c))
                    begin
                        r0.event_res   = EV_CHAR;
                        r0.token_class = CL_KEYWORD;
                        r0.out_char    = c;
                        n_res          = 2'd1;
                    end
                    else
                    begin
                        r0.event_res   = EV_END;
                        r0.token_class = CL_KEYWORD;
                        r1             = st.res;
                        n_res          = st.emit ? 2'd2 : 2'd1;
                        mode_next      = st.mode;
                        inc            = st.inc;
                    end
                end
                M_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        r0.event_res   = EV_END;
                        r0.token_class = CL_STRING;
                        n_res          = 2'd1;
                        mode_next      = M_IDLE;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        mode_next = M_ESCAPE;
                    end
                    else if (c == CH_NL)
                    begin
                        r0.event_res  = EV_ERROR;
                        r0.error_code = ERR_UNTERM;
                        n_res         = 2'd1;
                        mode_next     = M_ERR_STR;
                    end
                    else
                    begin
                        r0.event_res   = EV_CHAR;
                        r0.token_class = CL_STRING;
                        r0.out_char    = c;
                        n_res          = 2'd1;
                    end
                end
                M_ESCAPE:
                begin
                    r0.event_res   = EV_CHAR;
                    r0.token_class = CL_STRING;
                    r0.out_char    = c;
                    n_res          = 2'd1;
                    mode_next      = M_STRING;
                end
                default:
                begin
                    r0        = st.res;
                    n_res     = st.emit ? 2'd1 : 2'd0;
                    mode_next = st.mode;
                    inc       = st.inc;
                end
            endcase
        end
        // every result of one item sees the line count before the item
        r0.line_number = line_count_reg;
        r1.line_number = line_count_reg;
        r0.last        = (n_res == 2'd1);
        r1.last        = 1'b1;
    end

    // saturating line counter
    always_comb
    begin
        line_count_next = line_count_reg;
        if (in_xfer && inc && (line_count_reg != {LINE_BITS{1'b1}}))
        begin
            line_count_next = line_count_reg + {{(LINE_BITS-1){1'b0}}, 1'b1};
        end
    end

    // result queue: slot 0 is the output register, slot 1 the second result
    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (in_xfer)
        begin
            q0_next  = r0;
            q1_next  = r1;
            cnt_next = n_res;
        end
        else if (out_xfer)
        begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            line_count_reg <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (in_xfer)
            begin
                mode_reg <= mode_next;
            end
            line_count_reg <= line_count_next;
            cnt_reg        <= cnt_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    // checks
    `STT_ASSERT(a_cnt_range, cnt_reg != 2'd3, "result queue count out of range")
    `STT_ASSERT(a_line_mono, line_count_reg >= $past(line_count_reg), "line count went back")
    `STT_ASSERT_NEXT(a_err_sticky, mode_reg == M_ERR_CHAR || mode_reg == M_ERR_STR, mode_reg == $past(mode_reg), "error mode left")
    `STT_ASSERT_NEXT(a_err_one, in_xfer && (mode_reg == M_ERR_CHAR || mode_reg == M_ERR_STR), cnt_reg == 2'd1 && out_data.event_res == EV_ERROR, "error mode must give one error")

endmodule
